@@ hw/rtl/vec3n_pkg.sv @@
// vec3n_pkg: shared types and constants for the vector3 normalize block.
// Holds the controller state encoding and the command/status structs.
// Depends on nothing; every other file in hw/rtl uses it.
package vec3n_pkg;

  localparam int unsigned CompW    = 16;  // input component width
  localparam int unsigned MagW     = 17;  // magnitude of a component, up to 32768
  localparam int unsigned SumW     = 32;  // sum of squares
  localparam int unsigned LenW     = 16;  // floored length
  localparam int unsigned QuotW    = 15;  // unit magnitude, up to 16384
  localparam int unsigned NumComp  = 3;
  localparam int unsigned CntW     = 4;
  localparam int unsigned SelW     = 2;

  localparam logic [CntW-1:0] MulLast  = CntW'(NumComp - 1);
  localparam logic [CntW-1:0] SqrtLast = CntW'(LenW - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(QuotW - 1);
  localparam logic [SelW-1:0] CompLast = SelW'(NumComp - 1);

  localparam logic [SumW-1:0] SqrtBitInit = SumW'(1) << (SumW - 2);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SQRT = 6'b000100,
    S_DSET = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  typedef struct packed {
    logic            load;       // capture item, clear accumulators
    logic            mul_en;     // add square of selected magnitude
    logic            sqrt_step;  // one root bit
    logic            div_init;   // start division of selected component
    logic            div_step;   // one quotient bit
    logic            div_last;   // final quotient bit, store result
    logic            out_load;   // move results into output registers
    logic [SelW-1:0] sel;        // component index
  } cmd_t;

  typedef struct packed {
    logic len_zero;
  } sts_t;

endpackage

@@ hw/rtl/vec3n_ctrl.sv @@
// vec3n_ctrl: sequencer for the vector3 normalize block.
// Steps squaring, square root and the three divisions; owns both handshakes.
// Depends on vec3n_pkg.
module vec3n_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vec3n_pkg::cmd_t   cmd_o,
  input  vec3n_pkg::sts_t   sts_i
);

  vec3n_pkg::state_e                state_q, state_d;
  logic [vec3n_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [vec3n_pkg::SelW-1:0]       comp_q, comp_d;
  logic                             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    cmd_o   = '0;
    in_stall_o = 1'b1;
    case (state_q)
      vec3n_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = vec3n_pkg::S_MUL;
        end
      end
      vec3n_pkg::S_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.sel    = cnt_q[vec3n_pkg::SelW-1:0];
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == vec3n_pkg::MulLast) begin
          cnt_d   = '0;
          state_d = vec3n_pkg::S_SQRT;
        end
      end
      vec3n_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == vec3n_pkg::SqrtLast) begin
          comp_d  = '0;
          state_d = vec3n_pkg::S_DSET;
        end
      end
      vec3n_pkg::S_DSET: begin
        if (sts_i.len_zero) begin
          state_d = vec3n_pkg::S_FIN;
        end else begin
          cmd_o.div_init = 1'b1;
          cmd_o.sel      = comp_q;
          cnt_d          = '0;
          state_d        = vec3n_pkg::S_DIV;
        end
      end
      vec3n_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.sel      = comp_q;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == vec3n_pkg::DivLast) begin
          cmd_o.div_last = 1'b1;
          comp_d         = comp_q + 1'b1;
          state_d        = (comp_q == vec3n_pkg::CompLast) ? vec3n_pkg::S_FIN
                                                           : vec3n_pkg::S_DSET;
        end
      end
      vec3n_pkg::S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = vec3n_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vec3n_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vec3n_pkg::S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/vec3n_dp.sv @@
// vec3n_dp: datapath for the vector3 normalize block.
// Shared square accumulator, bit-serial root, one restoring divider, outputs.
// Depends on vec3n_pkg; driven by vec3n_ctrl commands.
module vec3n_dp (
  input  logic                                clk_i,
  input  vec3n_pkg::cmd_t                     cmd_i,
  output vec3n_pkg::sts_t                     sts_o,
  input  logic signed [vec3n_pkg::CompW-1:0]  vec_x_i,
  input  logic signed [vec3n_pkg::CompW-1:0]  vec_y_i,
  input  logic signed [vec3n_pkg::CompW-1:0]  vec_z_i,
  output logic signed [vec3n_pkg::CompW-1:0]  unit_x_o,
  output logic signed [vec3n_pkg::CompW-1:0]  unit_y_o,
  output logic signed [vec3n_pkg::CompW-1:0]  unit_z_o,
  output logic        [vec3n_pkg::LenW-1:0]   length_o,
  output logic                                zero_vector_o
);

  localparam int unsigned MagW  = vec3n_pkg::MagW;
  localparam int unsigned SumW  = vec3n_pkg::SumW;
  localparam int unsigned LenW  = vec3n_pkg::LenW;
  localparam int unsigned QuotW = vec3n_pkg::QuotW;
  localparam int unsigned CompW = vec3n_pkg::CompW;

  logic [MagW-1:0]   mag_q  [vec3n_pkg::NumComp];
  logic              neg_q  [vec3n_pkg::NumComp];
  logic [QuotW-1:0]  quo_q  [vec3n_pkg::NumComp];

  logic [SumW-1:0]   rem_q, root_q, bit_q;
  logic [LenW:0]     drem_q;
  logic [QuotW-1:0]  dvd_q, quot_q;

  logic [MagW-1:0]   mag_sel;
  logic [2*MagW-1:0] prod;
  logic [SumW:0]     trial;
  logic              root_ge;
  logic [LenW:0]     dtrial;
  logic              div_ge;
  logic [LenW-1:0]   len;

  function automatic logic [MagW-1:0] abs_mag(input logic signed [CompW-1:0] v);
    logic [MagW-1:0] ext;
    ext = MagW'(unsigned'(v));
    if (v[CompW-1]) begin
      ext = {1'b0, ~v} + 1'b1;
    end
    return ext;
  endfunction

  function automatic logic [CompW-1:0] apply_sign(input logic [QuotW-1:0] q,
                                                  input logic neg);
    logic [CompW-1:0] v;
    v = CompW'(q);
    return neg ? (~v + 1'b1) : v;
  endfunction

  assign len            = root_q[LenW-1:0];
  assign sts_o.len_zero = (len == '0);
  assign mag_sel        = mag_q[cmd_i.sel];
  assign prod           = mag_sel * mag_sel;
  assign trial          = {1'b0, root_q} + {1'b0, bit_q};
  assign root_ge        = {1'b0, rem_q} >= trial;
  assign dtrial         = {drem_q[LenW-1:0], dvd_q[QuotW-1]};
  assign div_ge         = dtrial >= {1'b0, len};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q[0] <= abs_mag(vec_x_i);
      mag_q[1] <= abs_mag(vec_y_i);
      mag_q[2] <= abs_mag(vec_z_i);
      neg_q[0] <= vec_x_i[CompW-1];
      neg_q[1] <= vec_y_i[CompW-1];
      neg_q[2] <= vec_z_i[CompW-1];
      rem_q    <= '0;
      root_q   <= '0;
      bit_q    <= vec3n_pkg::SqrtBitInit;
    end
    if (cmd_i.mul_en) begin
      rem_q <= rem_q + prod[SumW-1:0];
    end
    if (cmd_i.sqrt_step) begin
      if (root_ge) begin
        rem_q  <= rem_q - trial[SumW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      // magnitude never exceeds the length, so half of it fits below the divisor
      drem_q <= {1'b0, mag_sel[MagW-1:1]};
      dvd_q  <= {mag_sel[0], (QuotW-1)'(0)};
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      drem_q <= div_ge ? (dtrial - {1'b0, len}) : dtrial;
      dvd_q  <= dvd_q << 1;
      quot_q <= {quot_q[QuotW-2:0], div_ge};
      if (cmd_i.div_last) begin
        quo_q[cmd_i.sel] <= {quot_q[QuotW-2:0], div_ge};
      end
    end
    if (cmd_i.out_load) begin
      length_o      <= len;
      zero_vector_o <= sts_o.len_zero;
      if (sts_o.len_zero) begin
        unit_x_o <= '0;
        unit_y_o <= '0;
        unit_z_o <= '0;
      end else begin
        unit_x_o <= signed'(apply_sign(quo_q[0], neg_q[0]));
        unit_y_o <= signed'(apply_sign(quo_q[1], neg_q[1]));
        unit_z_o <= signed'(apply_sign(quo_q[2], neg_q[2]));
      end
    end
  end

endmodule

@@ hw/rtl/vector3_normalize_top.sv @@
// vector3_normalize_top: normalizes a signed 3-D vector to Q1.14 and reports its length.
// Instantiates vec3n_ctrl (sequencer) and vec3n_dp (datapath).
// Depends on vec3n_pkg.
//
//   channel  direction  handshake               payload
//   -------  ---------  ----------------------  -----------------------------------------
//   in       in         in_valid_i / in_stall_o  vec_x_i, vec_y_i, vec_z_i (s16)
//   out      out        out_valid_o / out_stall_i unit_x_o/y/z (s16 Q1.14), length_o (u16),
//                                                 zero_vector_o
//
// Sequence from accept to result: accept, squaring on the shared squarer, the root bit by bit,
// then per component on the one restoring divider a setup step and the quotient bits, and a move into
// the output register; a zero vector skips the divider. One item at a time.
// Reset clears the sequencer and the output valid; the datapath holds no control state.
// A stalled result sits in the output register while the next item is taken and worked;
// only the final transfer waits for the register.
module vector3_normalize_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vec3n_pkg::CompW-1:0]  vec_x_i,
  input  logic signed [vec3n_pkg::CompW-1:0]  vec_y_i,
  input  logic signed [vec3n_pkg::CompW-1:0]  vec_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vec3n_pkg::CompW-1:0]  unit_x_o,
  output logic signed [vec3n_pkg::CompW-1:0]  unit_y_o,
  output logic signed [vec3n_pkg::CompW-1:0]  unit_z_o,
  output logic        [vec3n_pkg::LenW-1:0]   length_o,
  output logic                                zero_vector_o
);

  // commands down to the datapath, status back up
  vec3n_pkg::cmd_t cmd;
  vec3n_pkg::sts_t sts;

  vec3n_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // squarer, root and divider share registers; results land in output registers
  vec3n_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .vec_z_i       (vec_z_i),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .unit_z_o      (unit_z_o),
    .length_o      (length_o),
    .zero_vector_o (zero_vector_o)
  );

endmodule

@@ tb/tb_vector3_normalize_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for vector3_normalize_top: a table of directed vectors, then random ones.
// Expected results come from an in-file normalizer model or a typed-in answer. Needs vec3n_pkg and the block's RTL.
module tb_vector3_normalize_top;

  // One input item: the three signed components.
  typedef struct packed {
    logic signed [vec3n_pkg::CompW-1:0] x;
    logic signed [vec3n_pkg::CompW-1:0] y;
    logic signed [vec3n_pkg::CompW-1:0] z;
  } vec_item_t;

  // One result item, laid out like the output ports.
  typedef struct packed {
    logic signed [vec3n_pkg::CompW-1:0] ux;
    logic signed [vec3n_pkg::CompW-1:0] uy;
    logic signed [vec3n_pkg::CompW-1:0] uz;
    logic        [vec3n_pkg::LenW-1:0]  len;
    logic                               zero;
  } unit_vec_t;

  // A row of the directed table. A row with a typed-in answer uses it
  // instead of the model's answer.
  typedef struct {
    vec_item_t vec;
    bit        fixed;
    unit_vec_t want;
  } stim_row_t;

  localparam int unsigned NumRandom = 800;
  localparam int unsigned IdlePct   = 36;
  // Count window with no idling or stalling on either side.
  localparam int unsigned QuietLo   = 300;
  localparam int unsigned QuietHi   = 460;
  // Extra wait after the last expected result, to catch stray results.
  localparam int unsigned DrainCycles = 100;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic signed [vec3n_pkg::CompW-1:0] vec_x_i = '0;
  logic signed [vec3n_pkg::CompW-1:0] vec_y_i = '0;
  logic signed [vec3n_pkg::CompW-1:0] vec_z_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic signed [vec3n_pkg::CompW-1:0] unit_x_o;
  logic signed [vec3n_pkg::CompW-1:0] unit_y_o;
  logic signed [vec3n_pkg::CompW-1:0] unit_z_o;
  logic        [vec3n_pkg::LenW-1:0]  length_o;
  logic                               zero_vector_o;

  stim_row_t stim_rows[$];
  unit_vec_t pending_units[$];
  int unsigned num_errors   = 0;
  int unsigned num_sent     = 0;
  int unsigned num_received = 0;
  int unsigned num_zero     = 0;

  vector3_normalize_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .vec_z_i       (vec_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .unit_z_o      (unit_z_o),
    .length_o      (length_o),
    .zero_vector_o (zero_vector_o)
  );

  always #10 clk_i = ~clk_i;

  // Divide one component, scaled by 2^14, by the length. Truncate toward zero.
  function automatic logic signed [vec3n_pkg::CompW-1:0] unit_of(
      int c, logic [vec3n_pkg::SumW-1:0] len);
    logic [vec3n_pkg::SumW-1:0] mag;
    logic [vec3n_pkg::SumW-1:0] quot;
    mag  = (c < 0) ? vec3n_pkg::SumW'(-c) : vec3n_pkg::SumW'(c);
    quot = (mag << 14) / len;
    return (c < 0) ? -quot[vec3n_pkg::CompW-1:0] : quot[vec3n_pkg::CompW-1:0];
  endfunction

  // Expected result for one vector: floored length by a bit-serial root,
  // then three divisions. A zero vector skips the divisions and sets the flag.
  function automatic unit_vec_t normalize_vec(vec_item_t v);
    int                         cx;
    int                         cy;
    int                         cz;
    logic [vec3n_pkg::SumW-1:0] ax;
    logic [vec3n_pkg::SumW-1:0] ay;
    logic [vec3n_pkg::SumW-1:0] az;
    logic [vec3n_pkg::SumW-1:0] rem;
    logic [vec3n_pkg::SumW-1:0] root;
    logic [vec3n_pkg::SumW-1:0] probe;
    unit_vec_t                  r;
    cx = v.x;
    cy = v.y;
    cz = v.z;
    ax = (cx < 0) ? vec3n_pkg::SumW'(-cx) : vec3n_pkg::SumW'(cx);
    ay = (cy < 0) ? vec3n_pkg::SumW'(-cy) : vec3n_pkg::SumW'(cy);
    az = (cz < 0) ? vec3n_pkg::SumW'(-cz) : vec3n_pkg::SumW'(cz);
    rem   = ax * ax + ay * ay + az * az;
    root  = '0;
    probe = vec3n_pkg::SqrtBitInit;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    r = '0;
    if (root == 0) begin
      r.zero = 1'b1;
    end else begin
      r.ux  = unit_of(cx, root);
      r.uy  = unit_of(cy, root);
      r.uz  = unit_of(cz, root);
      r.len = root[vec3n_pkg::LenW-1:0];
    end
    return r;
  endfunction

  function automatic vec_item_t mk_vec(int x, int y, int z);
    vec_item_t v;
    v.x = vec3n_pkg::CompW'(x);
    v.y = vec3n_pkg::CompW'(y);
    v.z = vec3n_pkg::CompW'(z);
    return v;
  endfunction

  function automatic unit_vec_t mk_unit(int ux, int uy, int uz, int len, bit zero);
    unit_vec_t u;
    u.ux   = vec3n_pkg::CompW'(ux);
    u.uy   = vec3n_pkg::CompW'(uy);
    u.uz   = vec3n_pkg::CompW'(uz);
    u.len  = vec3n_pkg::LenW'(len);
    u.zero = zero;
    return u;
  endfunction

  // Add a row whose answer is typed in.
  task automatic add_fixed(vec_item_t v, unit_vec_t u);
    stim_row_t row;
    row.vec   = v;
    row.fixed = 1'b1;
    row.want  = u;
    stim_rows.push_back(row);
  endtask

  // Add a row that the model answers.
  task automatic add_row(vec_item_t v);
    stim_row_t row;
    row.vec   = v;
    row.fixed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endtask

  // Component from the corners of the signed range.
  function automatic int corner_comp();
    case ($urandom_range(5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int small_comp();
    return int'($urandom_range(16)) - 8;
  endfunction

  function automatic int full_comp();
    return int'($signed(16'($urandom())));
  endfunction

  task automatic build_stimulus();
    int x;
    int y;
    int z;
    // Zero vector: no division, flag set, everything else zero.
    add_fixed(mk_vec(0, 0, 0), mk_unit(0, 0, 0, 0, 1'b1));
    // Vectors along one axis: the length equals the magnitude,
    // so the unit component is exactly +/-1.0.
    add_fixed(mk_vec(32767, 0, 0), mk_unit(16384, 0, 0, 32767, 1'b0));
    add_fixed(mk_vec(-32768, 0, 0), mk_unit(-16384, 0, 0, 32768, 1'b0));
    add_fixed(mk_vec(0, -32768, 0), mk_unit(0, -16384, 0, 32768, 1'b0));
    add_fixed(mk_vec(0, 0, 32767), mk_unit(0, 0, 16384, 32767, 1'b0));
    add_fixed(mk_vec(1, 0, 0), mk_unit(16384, 0, 0, 1, 1'b0));
    add_fixed(mk_vec(0, -1, 0), mk_unit(0, -16384, 0, 1, 1'b0));
    add_fixed(mk_vec(0, 0, -1), mk_unit(0, 0, -16384, 1, 1'b0));
    // Largest sum of squares, and other mixed corners.
    add_row(mk_vec(-32768, -32768, -32768));
    add_row(mk_vec(32767, 32767, 32767));
    add_row(mk_vec(-32768, 32767, -1));
    add_row(mk_vec(32767, -32768, 32767));
    // Small vectors with exact and floored lengths; for +/-(1, 1, 1) the
    // floored root equals the magnitude of every component.
    add_row(mk_vec(1, 1, 1));
    add_row(mk_vec(-1, -1, -1));
    add_row(mk_vec(2, 2, 1));
    add_row(mk_vec(3, 4, 0));
    add_row(mk_vec(12, -16, 21));
    add_row(mk_vec(-21845, 10922, 5461));
    add_row(mk_vec(16'h5555, 16'hAAAA, 16'h7FFF));
    add_row(mk_vec(-256, 0, 255));

    repeat (NumRandom) begin
      case ($urandom_range(9))
        5, 6: begin
          x = small_comp();
          y = small_comp();
          z = small_comp();
        end
        7: begin
          x = corner_comp();
          y = corner_comp();
          z = corner_comp();
        end
        8: begin
          // One large component with two small ones.
          x = full_comp();
          y = small_comp();
          z = small_comp();
          case ($urandom_range(2))
            0: begin
              y = x;
              x = small_comp();
            end
            1: begin
              z = x;
              x = small_comp();
            end
            default: ;
          endcase
        end
        9: begin
          // Spread the magnitudes over all scales.
          x = full_comp() >>> $urandom_range(15);
          y = full_comp() >>> $urandom_range(15);
          z = full_comp() >>> $urandom_range(15);
        end
        default: begin
          x = full_comp();
          y = full_comp();
          z = full_comp();
        end
      endcase
      add_row(mk_vec(x, y, z));
    end
  endtask

  // Compare a result item with the oldest expectation, field by field.
  task automatic check_result(unit_vec_t want, unit_vec_t got);
    if (got.ux !== want.ux) begin
      $display("%0t: unit_x mismatch: expected %0d, actual %0d", $time, want.ux, got.ux);
      num_errors++;
    end
    if (got.uy !== want.uy) begin
      $display("%0t: unit_y mismatch: expected %0d, actual %0d", $time, want.uy, got.uy);
      num_errors++;
    end
    if (got.uz !== want.uz) begin
      $display("%0t: unit_z mismatch: expected %0d, actual %0d", $time, want.uz, got.uz);
      num_errors++;
    end
    if (got.len !== want.len) begin
      $display("%0t: length mismatch: expected %0d, actual %0d", $time, want.len, got.len);
      num_errors++;
    end
    if (got.zero !== want.zero) begin
      $display("%0t: zero_vector mismatch: expected %0b, actual %0b",
               $time, want.zero, got.zero);
      num_errors++;
    end
  endtask

  // Result side: take the item on each accepted transfer, then pick the
  // stall for the next cycle. No stalling inside the quiet window.
  always @(posedge clk_i) begin
    unit_vec_t got;
    bit        quiet;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {unit_x_o, unit_y_o, unit_z_o, length_o, zero_vector_o};
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected result item: ux %0d uy %0d uz %0d len %0d zero %0b",
                 $time, got.ux, got.uy, got.uz, got.len, got.zero);
        num_errors++;
      end else begin
        check_result(pending_units.pop_front(), got);
      end
      if (got.zero) num_zero++;
      num_received++;
    end
    quiet = (num_received >= QuietLo) && (num_received < QuietHi);
    out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
  end

  // Input side and end of run.
  initial begin
    int unsigned idx;
    bit          quiet;
    vec_item_t   vec;
    build_stimulus();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    idx = 0;
    while (idx < stim_rows.size()) begin
      @(posedge clk_i);
      // Record the expectation for an item accepted at this edge.
      if (in_valid_i && !in_stall_o) begin
        if (stim_rows[idx].fixed) begin
          pending_units.push_back(stim_rows[idx].want);
        end else begin
          pending_units.push_back(normalize_vec(stim_rows[idx].vec));
        end
        num_sent++;
        idx++;
      end
      // Hold a stalled item. Otherwise present the next one or idle.
      if (!(in_valid_i && in_stall_o)) begin
        quiet = (idx >= QuietLo) && (idx < QuietHi);
        if (idx < stim_rows.size() && (quiet || $urandom_range(99) >= IdlePct)) begin
          vec = stim_rows[idx].vec;
          in_valid_i <= 1'b1;
          vec_x_i    <= vec.x;
          vec_y_i    <= vec.y;
          vec_z_i    <= vec.z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end

    // Drain the results, then watch for stray items.
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d vectors (%0d from the directed table), received %0d results, %0d zero.",
             num_sent, 20, num_received, num_zero);
    $display("Mismatches or stray results: %0d", num_errors);
    if (num_errors == 0) begin
      $display("vector3_normalize_top test passed");
    end else begin
      $display("vector3_normalize_top test failed");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected", pending_units.size());
    $display("vector3_normalize_top test failed");
    $finish;
  end

endmodule

@@ vector3_normalize_top.f @@
hw/rtl/vec3n_pkg.sv
hw/rtl/vec3n_ctrl.sv
hw/rtl/vec3n_dp.sv
hw/rtl/vector3_normalize_top.sv
tb/tb_vector3_normalize_top.sv
